### sv/expression_lexer_top_macros.svh
// Assertion macros for the expression lexer.
`ifndef EXPRESSION_LEXER_TOP_MACROS_SVH
`define EXPRESSION_LEXER_TOP_MACROS_SVH

// same-cycle implication
`define ELX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ELX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/elx_pkg.sv
// Types, character codes and helper functions shared by the expression lexer.
package elx_pkg;

   typedef enum logic [3:0] {
      TOK_LITERAL      = 4'd0,
      TOK_IDENT        = 4'd1,
      TOK_KW_INT       = 4'd2,
      TOK_EQ           = 4'd3,
      TOK_ASSIGN       = 4'd4,
      TOK_ADD          = 4'd5,
      TOK_SUB          = 4'd6,
      TOK_MUL          = 4'd7,
      TOK_DIV          = 4'd8,
      TOK_END          = 4'd9,
      TOK_BAD_CHAR     = 4'd10,
      TOK_OPEN_COMMENT = 4'd11
   } token_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_NUMBER  = 3'd1,
      MODE_NAME    = 3'd2,
      MODE_EQUAL   = 3'd3,
      MODE_COMMENT = 3'd4,
      MODE_DROP    = 3'd5
   } lexer_mode_type;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_KW_I    = 8'h69;
   localparam logic [7:0] CHAR_KW_N    = 8'h6E;
   localparam logic [7:0] CHAR_KW_T    = 8'h74;

   localparam logic [1:0] KW_LENGTH = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_LVL_W = 3;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_word_type;

   typedef struct packed {
      token_kind_type token_kind;
      logic [31:0]    int_value;
      logic           int_overflow;
      logic [31:0]    name_start;
      logic [7:0]     name_length;
      logic           last_of_run;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

   typedef struct packed {
      logic                   room;
      logic [QUEUE_LVL_W-1:0] level;
   } queue_status_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic [7:0] kw_char(logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = CHAR_KW_I;
         2'd1:    ch = CHAR_KW_N;
         2'd2:    ch = CHAR_KW_T;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic token_type make_token(token_kind_type kind);
      token_type t;
      t = '0;
      t.token_kind = kind;
      return t;
   endfunction

endpackage

### sv/elx_req_if.sv
// Source byte channel of the expression lexer.
interface elx_req_if;
   import elx_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_input;

   modport source (output valid, output char_code, output end_of_input, input ready);
   modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

### sv/elx_rsp_if.sv
// Token channel of the expression lexer.
interface elx_rsp_if;
   import elx_pkg::*;

   logic           valid;
   logic           ready;
   token_kind_type token_kind;
   logic [31:0]    int_value;
   logic           int_overflow;
   logic [31:0]    name_start;
   logic [7:0]     name_length;
   logic           last_of_run;

   modport source (output valid, output token_kind, output int_value, output int_overflow,
                   output name_start, output name_length, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input int_value, input int_overflow,
                 input name_start, input name_length, input last_of_run, output ready);
endinterface

### sv/elx_core.sv
// Lexer state machine: mode, literal accumulator, name tracking and token build.
module elx_core #(
   parameter int VALUE_WIDTH     = 32,
   parameter int MAX_NAME_LENGTH = 255
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  elx_pkg::req_word_type item,
   output elx_pkg::push_type     push
);
   import elx_pkg::*;

   localparam int NAME_W = $clog2(MAX_NAME_LENGTH + 1);
   localparam int SUM_W  = VALUE_WIDTH + 4;

   lexer_mode_type         mode_ff, mode_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;
   logic [31:0]            start_ff, start_in;
   logic [NAME_W-1:0]      len_ff, len_in;
   logic [1:0]             kp_ff, kp_in;
   logic [31:0]            pos_ff, pos_in;

   logic [7:0]       c;
   logic [3:0]       digit;
   logic [SUM_W-1:0] wide_acc;
   logic [SUM_W-1:0] sum;
   logic             sum_over;
   logic             pend_valid;
   token_type        pend_tok;
   logic             flush_valid;
   logic             second_valid;
   token_type        second_tok;
   logic             fresh;

   assign c        = item.char_code;
   assign digit    = 4'(c - CHAR_ZERO);
   assign wide_acc = SUM_W'(acc_ff);
   assign sum      = (wide_acc << 3) + (wide_acc << 1) + SUM_W'(digit);
   assign sum_over = |sum[SUM_W-1:VALUE_WIDTH];

   // token held back for lookahead
   always_comb begin
      pend_valid = 1'b0;
      pend_tok   = make_token(TOK_ASSIGN);
      case (mode_ff)
         MODE_NUMBER: begin
            pend_valid            = 1'b1;
            pend_tok              = make_token(TOK_LITERAL);
            pend_tok.int_value    = 32'(acc_ff);
            pend_tok.int_overflow = ovf_ff;
         end
         MODE_NAME: begin
            pend_valid = 1'b1;
            if (len_ff == NAME_W'(KW_LENGTH) && kp_ff == KW_LENGTH) begin
               pend_tok = make_token(TOK_KW_INT);
            end else begin
               pend_tok             = make_token(TOK_IDENT);
               pend_tok.name_start  = start_ff;
               pend_tok.name_length = 8'(len_ff);
            end
         end
         MODE_EQUAL: begin
            pend_valid = 1'b1;
         end
         default: begin
            pend_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      start_in     = start_ff;
      len_in       = len_ff;
      kp_in        = kp_ff;
      pos_in       = pos_ff + 32'd1;
      flush_valid  = 1'b0;
      second_valid = 1'b0;
      second_tok   = make_token(TOK_END);
      fresh        = 1'b0;

      if (item.end_of_input) begin
         flush_valid  = pend_valid;
         second_valid = 1'b1;
         second_tok   = make_token((mode_ff == MODE_COMMENT) ? TOK_OPEN_COMMENT : TOK_END);
         mode_in      = MODE_IDLE;
         acc_in       = '0;
         ovf_in       = 1'b0;
         start_in     = '0;
         len_in       = '0;
         kp_in        = '0;
         pos_in       = '0;
      end else begin
         unique case (mode_ff)
            MODE_DROP: begin
               mode_in = MODE_DROP;
            end
            MODE_COMMENT: begin
               if (c == CHAR_HASH) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(c)) begin
                  if (sum_over) begin
                     acc_in = '1;
                     ovf_in = 1'b1;
                  end else begin
                     acc_in = sum[VALUE_WIDTH-1:0];
                  end
               end else begin
                  flush_valid = 1'b1;
                  mode_in     = MODE_IDLE;
                  fresh       = 1'b1;
               end
            end
            MODE_NAME: begin
               if (is_alpha(c) || is_digit(c)) begin
                  if (len_ff == NAME_W'(kp_ff) && kp_ff < KW_LENGTH && c == kw_char(kp_ff)) begin
                     kp_in = kp_ff + 2'd1;
                  end
                  if (len_ff < NAME_W'(MAX_NAME_LENGTH)) begin
                     len_in = len_ff + NAME_W'(1);
                  end
               end else begin
                  flush_valid = 1'b1;
                  mode_in     = MODE_IDLE;
                  fresh       = 1'b1;
               end
            end
            MODE_EQUAL: begin
               mode_in = MODE_IDLE;
               if (c == CHAR_EQUAL) begin
                  second_valid = 1'b1;
                  second_tok   = make_token(TOK_EQ);
               end else begin
                  flush_valid = 1'b1;
                  fresh       = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               fresh   = 1'b1;
            end
         endcase

         if (fresh) begin
            if (c == CHAR_NEWLINE || c == CHAR_SPACE) begin
               mode_in = MODE_IDLE;
            end else if (c == CHAR_HASH) begin
               mode_in = MODE_COMMENT;
            end else if (is_digit(c)) begin
               mode_in = MODE_NUMBER;
               acc_in  = VALUE_WIDTH'(digit);
               ovf_in  = 1'b0;
            end else if (c == CHAR_EQUAL) begin
               mode_in = MODE_EQUAL;
            end else if (c == CHAR_PLUS) begin
               second_valid = 1'b1;
               second_tok   = make_token(TOK_ADD);
            end else if (c == CHAR_MINUS) begin
               second_valid = 1'b1;
               second_tok   = make_token(TOK_SUB);
            end else if (c == CHAR_STAR) begin
               second_valid = 1'b1;
               second_tok   = make_token(TOK_MUL);
            end else if (c == CHAR_SLASH) begin
               second_valid = 1'b1;
               second_tok   = make_token(TOK_DIV);
            end else if (is_alpha(c)) begin
               mode_in  = MODE_NAME;
               start_in = pos_ff;
               len_in   = NAME_W'(1);
               kp_in    = (c == CHAR_KW_I) ? 2'd1 : 2'd0;
            end else begin
               second_valid = 1'b1;
               second_tok   = make_token(TOK_BAD_CHAR);
               mode_in      = MODE_DROP;
            end
         end
      end
   end

   // pack flushed token ahead of the new one
   always_comb begin
      push.count              = 2'(flush_valid) + 2'(second_valid);
      push.first              = flush_valid ? pend_tok : second_tok;
      push.first.last_of_run  = !(flush_valid && second_valid);
      push.second             = second_tok;
      push.second.last_of_run = 1'b1;
      if (!take) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         start_ff <= '0;
         len_ff   <= '0;
         kp_ff    <= '0;
         pos_ff   <= '0;
      end else if (take) begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         kp_ff    <= kp_in;
         pos_ff   <= pos_in;
      end
   end
endmodule

### sv/elx_queue.sv
// Token queue: takes up to two tokens a cycle, hands out one per word.
module elx_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  elx_pkg::push_type         push,
   output elx_pkg::queue_status_type status,
   elx_rsp_if.source                 rsp_chan
);
   import elx_pkg::*;

   token_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LVL_W-1:0] level_ff, level_in;
   logic                   pop;
   token_type              head;

   assign head  = mem_ff[rd_ptr_ff];
   assign pop   = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.valid        = (level_ff != '0);
   assign rsp_chan.token_kind   = head.token_kind;
   assign rsp_chan.int_value    = head.int_value;
   assign rsp_chan.int_overflow = head.int_overflow;
   assign rsp_chan.name_start   = head.name_start;
   assign rsp_chan.name_length  = head.name_length;
   assign rsp_chan.last_of_run  = head.last_of_run;

   assign status.level = level_ff;
   assign status.room  = (level_ff <= QUEUE_LVL_W'(QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      level_in  = level_ff + QUEUE_LVL_W'(push.count) - QUEUE_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + QUEUE_PTR_W'(1)] <= push.second;
      end
   end
endmodule

### sv/expression_lexer_top.sv
// Expression lexer top level: input word register, lexer core and token queue.
//
//   channel    dir  handshake              payload
//   req_chan   in   valid / ready          char_code, end_of_input
//   rsp_chan   out  valid / ready          token_kind, int_value, int_overflow,
//                                          name_start, name_length, last_of_run
//
// One source word enters the input register per cycle unless it is held, and is lexed
// once the queue has room. Each word yields zero, one or two tokens; the queue drains one
// token per cycle while rsp_chan.ready is high, so two-token words back up the input.
// Synchronous reset returns the lexer to idle at byte position zero and empties the queue.
// The input register holds a word while the queue has fewer than two free slots.
module expression_lexer_top #(
   parameter int VALUE_WIDTH     = 32,
   parameter int MAX_NAME_LENGTH = 255
) (
   input  logic      clock,
   input  logic      reset,
   elx_req_if.sink   req_chan,
   elx_rsp_if.source rsp_chan
);
   import elx_pkg::*;

   `include "expression_lexer_top_macros.svh"

   logic             in_valid_ff, in_valid_in;
   req_word_type     in_word_ff;
   logic             take;
   logic             req_accept;
   push_type         push;
   queue_status_type status;

   assign take           = in_valid_ff && status.room;
   assign req_chan.ready = !in_valid_ff || take;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_word_ff.char_code    <= req_chan.char_code;
         in_word_ff.end_of_input <= req_chan.end_of_input;
      end
   end

   elx_core #(
      .VALUE_WIDTH     (VALUE_WIDTH),
      .MAX_NAME_LENGTH (MAX_NAME_LENGTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .item  (in_word_ff),
      .push  (push)
   );

   elx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .status   (status),
      .rsp_chan (rsp_chan)
   );

   `ELX_ASSERT_NOW(a_end_emits_token, clock, reset, take && in_word_ff.end_of_input, push.count != 2'd0, "end of input produced no token")
   `ELX_ASSERT_NOW(a_pair_marks_last, clock, reset, push.count == 2'd2, !push.first.last_of_run && push.second.last_of_run, "token pair has wrong last_of_run marks")
   `ELX_ASSERT_NEXT(a_queue_bound, clock, reset, push.count != 2'd0, status.level <= QUEUE_LVL_W'(QUEUE_DEPTH), "token queue overrun")
endmodule

### verif/elx_token_checker.sv
`timescale 1ns / 100ps
// Token checker for the expression lexer: predicts tokens from accepted words and compares them.
module elx_token_checker
   import elx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   elx_req_if          req_chan,
   elx_rsp_if          rsp_chan,
   output int          mismatch_count,
   output int          tokens_pending,
   output int          words_lexed,
   output int          tokens_checked,
   output logic [11:0] kinds_seen
);

   localparam longint     VALUE_CEILING = 64'h0000_0000_FFFF_FFFF;
   localparam logic [7:0] NAME_LEN_MAX  = 8'd255;

   lexer_mode_type mode_q;
   logic [31:0]    value_acc;
   logic           value_sat;
   logic [31:0]    name_pos;
   logic [7:0]     name_len;
   logic [1:0]     kw_match;
   logic [31:0]    byte_count;

   token_type      expected_tokens[$];
   int             fail_tally;
   int             live_words;
   int             token_tally;
   logic [11:0]    kind_mask;

   function automatic logic is_numeral(logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic void clear_lexer();
      mode_q     = MODE_IDLE;
      value_acc  = '0;
      value_sat  = 1'b0;
      name_pos   = '0;
      name_len   = '0;
      kw_match   = '0;
      byte_count = '0;
   endfunction

   function automatic void push_token(token_kind_type kind, logic [31:0] val, logic ovf,
                                      logic [31:0] start, logic [7:0] len);
      token_type t;
      t              = '0;
      t.token_kind   = kind;
      t.int_value    = val;
      t.int_overflow = ovf;
      t.name_start   = start;
      t.name_length  = len;
      expected_tokens.push_back(t);
   endfunction

   function automatic void accumulate(logic [3:0] digit);
      if (longint'(value_acc) > (VALUE_CEILING - digit) / 10) begin
         value_acc = VALUE_CEILING[31:0];
         value_sat = 1'b1;
      end else begin
         value_acc = 32'(longint'(value_acc) * 10 + digit);
      end
   endfunction

   // emit the token held for lookahead, if any, and drop back to idle from a token mode
   function automatic void flush_pending();
      case (mode_q)
         MODE_NUMBER: push_token(TOK_LITERAL, value_acc, value_sat, '0, '0);
         MODE_NAME: begin
            if (name_len == 8'd3 && kw_match == KW_LENGTH)
               push_token(TOK_KW_INT, '0, 1'b0, '0, '0);
            else
               push_token(TOK_IDENT, '0, 1'b0, name_pos, name_len);
         end
         MODE_EQUAL: push_token(TOK_ASSIGN, '0, 1'b0, '0, '0);
         default: ;
      endcase
      if (mode_q inside {MODE_NUMBER, MODE_NAME, MODE_EQUAL})
         mode_q = MODE_IDLE;
   endfunction

   function automatic void start_lexeme(logic [7:0] c);
      if (c == CHAR_NEWLINE || c == CHAR_SPACE) begin
      end else if (c == CHAR_HASH) begin
         mode_q = MODE_COMMENT;
      end else if (is_numeral(c)) begin
         mode_q    = MODE_NUMBER;
         value_acc = '0;
         value_sat = 1'b0;
         accumulate(4'(c - CHAR_ZERO));
      end else if (c == CHAR_EQUAL) begin
         mode_q = MODE_EQUAL;
      end else if (c == CHAR_PLUS) begin
         push_token(TOK_ADD, '0, 1'b0, '0, '0);
      end else if (c == CHAR_MINUS) begin
         push_token(TOK_SUB, '0, 1'b0, '0, '0);
      end else if (c == CHAR_STAR) begin
         push_token(TOK_MUL, '0, 1'b0, '0, '0);
      end else if (c == CHAR_SLASH) begin
         push_token(TOK_DIV, '0, 1'b0, '0, '0);
      end else if (is_letter(c)) begin
         mode_q   = MODE_NAME;
         name_pos = byte_count;
         name_len = 8'd1;
         kw_match = (c == CHAR_KW_I) ? 2'd1 : 2'd0;
      end else begin
         push_token(TOK_BAD_CHAR, '0, 1'b0, '0, '0);
         mode_q = MODE_DROP;
      end
   endfunction

   function automatic void lex_word(logic [7:0] c, logic mark);
      int   held;
      logic fresh;
      logic in_comment;
      held  = expected_tokens.size();
      fresh = 1'b1;
      if (mark) begin
         in_comment = (mode_q == MODE_COMMENT);
         flush_pending();
         if (in_comment)
            push_token(TOK_OPEN_COMMENT, '0, 1'b0, '0, '0);
         else
            push_token(TOK_END, '0, 1'b0, '0, '0);
         clear_lexer();
      end else begin
         case (mode_q)
            MODE_DROP: fresh = 1'b0;
            MODE_COMMENT: begin
               if (c == CHAR_HASH)
                  mode_q = MODE_IDLE;
               fresh = 1'b0;
            end
            MODE_NUMBER: begin
               if (is_numeral(c)) begin
                  accumulate(4'(c - CHAR_ZERO));
                  fresh = 1'b0;
               end else begin
                  flush_pending();
               end
            end
            MODE_NAME: begin
               if (is_letter(c) || is_numeral(c)) begin
                  if (name_len == {6'd0, kw_match} &&
                      ((kw_match == 2'd0 && c == CHAR_KW_I) ||
                       (kw_match == 2'd1 && c == CHAR_KW_N) ||
                       (kw_match == 2'd2 && c == CHAR_KW_T)))
                     kw_match = kw_match + 2'd1;
                  if (name_len < NAME_LEN_MAX)
                     name_len = name_len + 8'd1;
                  fresh = 1'b0;
               end else begin
                  flush_pending();
               end
            end
            MODE_EQUAL: begin
               if (c == CHAR_EQUAL) begin
                  push_token(TOK_EQ, '0, 1'b0, '0, '0);
                  mode_q = MODE_IDLE;
                  fresh  = 1'b0;
               end else begin
                  flush_pending();
               end
            end
            default: mode_q = MODE_IDLE;
         endcase
         if (fresh)
            start_lexeme(c);
         byte_count = byte_count + 32'd1;
      end
      if (expected_tokens.size() > held)
         expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_tally++;
      end
   endfunction

   function automatic void check_token();
      token_type want;
      token_tally++;
      kind_mask[rsp_chan.token_kind] = 1'b1;
      if (expected_tokens.size() == 0) begin
         $error("token_kind: expected none, actual %0d", rsp_chan.token_kind);
         fail_tally++;
      end else begin
         want = expected_tokens.pop_front();
         compare_field("token_kind", 32'(want.token_kind), 32'(rsp_chan.token_kind));
         compare_field("int_value", want.int_value, rsp_chan.int_value);
         compare_field("int_overflow", 32'(want.int_overflow), 32'(rsp_chan.int_overflow));
         compare_field("name_start", want.name_start, rsp_chan.name_start);
         compare_field("name_length", 32'(want.name_length), 32'(rsp_chan.name_length));
         compare_field("last_of_run", 32'(want.last_of_run), 32'(rsp_chan.last_of_run));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_lexer();
         expected_tokens.delete();
         fail_tally  = 0;
         live_words  = 0;
         token_tally = 0;
         kind_mask   = '0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            check_token();
         if (req_chan.valid && req_chan.ready) begin
            live_words++;
            lex_word(req_chan.char_code, req_chan.end_of_input);
         end
      end
      mismatch_count <= fail_tally;
      tokens_pending <= expected_tokens.size();
      words_lexed    <= live_words;
      tokens_checked <= token_tally;
      kinds_seen     <= kind_mask;
   end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for the expression lexer: clock, reset, source words, back-pressure and verdict.
module tb;
   import elx_pkg::*;

   localparam int WORD_TARGET = 450;
   localparam int IDLE_PCT    = 16;
   localparam int STALL_LIMIT = 2000;

   logic        clock;
   logic        reset;
   int          idle_pct;
   int          quiet_cycles;
   int          mismatch_count;
   int          tokens_pending;
   int          words_lexed;
   int          tokens_checked;
   logic [11:0] kinds_seen;

   elx_req_if req_chan ();
   elx_rsp_if rsp_chan ();

   expression_lexer_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   elx_token_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (mismatch_count),
      .tokens_pending (tokens_pending),
      .words_lexed    (words_lexed),
      .tokens_checked (tokens_checked),
      .kinds_seen     (kinds_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] random_letter();
      if ($urandom_range(0, 1) != 0)
         return 8'("a") + 8'($urandom_range(0, 25));
      return 8'("A") + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] random_blank();
      return ($urandom_range(0, 1) != 0) ? CHAR_SPACE : CHAR_NEWLINE;
   endfunction

   function automatic logic [7:0] comment_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == CHAR_HASH);
      return b;
   endfunction

   // hold the word until accepted; the next call lowers valid only on a gap
   task automatic send_word(input logic [7:0] code, input logic mark);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.char_code    <= code;
      req_chan.end_of_input <= mark;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   task automatic send_text(input string s);
      foreach (s[i])
         send_word(s[i], 1'b0);
   endtask

   task automatic send_mark();
      send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_name(input int len);
      send_word(random_letter(), 1'b0);
      repeat (len - 1)
         send_word(($urandom_range(0, 2) == 0) ? random_digit() : random_letter(), 1'b0);
   endtask

   task automatic send_lexeme();
      string near_miss[4];
      int    n;
      near_miss = '{"i", "in", "int0", "integer"};
      case ($urandom_range(0, 19))
         0, 1, 2, 3: begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
            repeat (n)
               send_word(random_digit(), 1'b0);
         end
         4, 5, 6: send_name($urandom_range(1, 8));
         7:       send_text("int");
         8:       send_text(near_miss[$urandom_range(0, 3)]);
         9:       send_word(CHAR_PLUS, 1'b0);
         10:      send_word(CHAR_MINUS, 1'b0);
         11:      send_word(CHAR_STAR, 1'b0);
         12:      send_word(CHAR_SLASH, 1'b0);
         13:      send_word(CHAR_EQUAL, 1'b0);
         14:      send_text("==");
         15: begin
            send_word(CHAR_HASH, 1'b0);
            repeat ($urandom_range(0, 5))
               send_word(comment_byte(), 1'b0);
            send_word(CHAR_HASH, 1'b0);
         end
         16: begin
            send_word(CHAR_HASH, 1'b0);
            repeat ($urandom_range(0, 3))
               send_word(comment_byte(), 1'b0);
         end
         17:      send_word(8'($urandom_range(0, 255)), 1'b0);
         default: send_word(random_blank(), 1'b0);
      endcase
   endtask

   task automatic send_sentence();
      repeat ($urandom_range(1, 8)) begin
         send_lexeme();
         if ($urandom_range(0, 3) == 0)
            send_word(random_blank(), 1'b0);
      end
      send_mark();
   endtask

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.char_code    <= '0;
      req_chan.end_of_input <= 1'b0;
      idle_pct = IDLE_PCT;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_text("int a=4294967296*-/+");
      send_mark();
      send_text("b==#c");
      send_mark();
      send_word(8'hFF, 1'b0);
      send_word(8'h09, 1'b0);
      send_mark();
      send_word(8'h00, 1'b0);
      send_mark();
      send_name($urandom_range(256, 270));
      send_mark();

      while (words_lexed < WORD_TARGET) begin
         idle_pct = (words_lexed >= 320 && words_lexed < 420) ? 0 : IDLE_PCT;
         send_sentence();
      end
      req_chan.valid <= 1'b0;
      idle_pct = IDLE_PCT;

      @(posedge clock);
      wait (tokens_pending == 0);
      repeat (10) @(posedge clock);

      $display("Lexed %0d source words into %0d tokens; token kinds seen mask %03h.",
               words_lexed, tokens_checked, kinds_seen);
      if (mismatch_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
